[sv/vvc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vvc_pkg: shared types and constants for the varbit varint codec
// Transaction payloads, operation and result codes, state encoding and
// per-width group tables.
// ----------------------------------------------------------------------------
package vvc_pkg;

  localparam int VALUE_W = 64;
  localparam int SH_W    = VALUE_W + 7;
  localparam int POS_W   = $clog2(SH_W);
  localparam int CNT_W   = $clog2(VALUE_W + 1);

  localparam logic FUNC_ENCODE = 1'b0;
  localparam logic FUNC_DECODE = 1'b1;

  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_VALUE = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic [7:0] BAD_HEADER = 8'hff;

  // bit position of the top group window, per group width
  localparam logic [POS_W-1:0] TOP_POS [8] = '{
    POS_W'(0),
    POS_W'(1 * ((VALUE_W + 0) / 1 - 1)),
    POS_W'(2 * ((VALUE_W + 1) / 2 - 1)),
    POS_W'(3 * ((VALUE_W + 2) / 3 - 1)),
    POS_W'(4 * ((VALUE_W + 3) / 4 - 1)),
    POS_W'(5 * ((VALUE_W + 4) / 5 - 1)),
    POS_W'(6 * ((VALUE_W + 5) / 6 - 1)),
    POS_W'(7 * ((VALUE_W + 6) / 7 - 1))
  };

  // number of groups in a full value, per group width
  localparam logic [CNT_W-1:0] NGRP [8] = '{
    CNT_W'(0),
    CNT_W'((VALUE_W + 0) / 1),
    CNT_W'((VALUE_W + 1) / 2),
    CNT_W'((VALUE_W + 2) / 3),
    CNT_W'((VALUE_W + 3) / 4),
    CNT_W'((VALUE_W + 4) / 5),
    CNT_W'((VALUE_W + 5) / 6),
    CNT_W'((VALUE_W + 6) / 7)
  };

  // width marker ORed into the first byte: ones above bit g
  localparam logic [7:0] MARK [8] = '{
    8'h00, 8'hfc, 8'hf8, 8'hf0, 8'he0, 8'hc0, 8'h80, 8'h00
  };

  typedef struct packed {
    logic        func;
    logic [63:0] value;
    logic [7:0]  in_byte;
    logic        in_last;
  } vvc_in_t;

  typedef struct packed {
    logic [1:0]  out_kind;
    logic [7:0]  out_byte;
    logic        out_last;
    logic [63:0] out_value;
  } vvc_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ENC,
    ST_ZERO,
    ST_DOUT
  } vvc_state_t;

endpackage

[sv/varbit_varint_codec_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// varbit_varint_codec_core: big-endian variable-length integer codec
// Encodes 64-bit values into marker-prefixed byte runs and decodes byte
// streams back into values, with 1 to 7 payload bits per byte.
// ----------------------------------------------------------------------------
// An encode transaction moves the value through a shift register one group
// at a time, ceil(64/g) groups for g payload bits per byte (64 for g = 1,
// 10 for g = 7); leading zero groups give no byte. Zero is sent as a single
// byte. Decode takes one byte per cycle until the byte marked last, after
// which input stalls until its result is loaded. Output back-pressure stalls
// the encode, zero and result states. group_bits sets the encode width and
// the user must write it only while the block is idle; the block itself
// does not enforce this.
module varbit_varint_codec_core
  import vvc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  vvc_in_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output vvc_out_t    out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  vvc_state_t          state_r, state_nxt;
  logic [2:0]          grp_bits_r;
  logic [SH_W-1:0]     enc_sh_r, enc_sh_nxt;
  logic [CNT_W-1:0]    enc_cnt_r, enc_cnt_nxt;
  logic                enc_found_r, enc_found_nxt;
  logic [VALUE_W-1:0]  dec_acc_r, dec_acc_nxt;
  logic [2:0]          dec_gb_r, dec_gb_nxt;
  logic                dec_first_r, dec_first_nxt;
  logic                dec_bad_r, dec_bad_nxt;
  logic                out_valid_r, out_valid_nxt;
  vvc_out_t            out_data_r, out_data_nxt;

  logic                can_emit;
  logic [6:0]          enc_win;
  logic [6:0]          enc_grp;
  logic [2:0]          hdr_g;

  // configuration port
  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {29'd0, grp_bits_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grp_bits_r <= 3'd7;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      grp_bits_r <= pwdata[2:0];
    end
  end

  // top group window of the encode shift register
  always_comb begin
    enc_win = 7'd0;
    for (int k = 1; k < 8; k++) begin
      if (grp_bits_r == 3'(k)) begin
        enc_win = enc_sh_r[TOP_POS[k] +: 7];
      end
    end
    enc_grp = enc_win & ~(7'h7f << grp_bits_r);
  end

  // width from a first byte: highest clear bit
  always_comb begin
    hdr_g = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (!in_data.in_byte[i]) begin
        hdr_g = 3'(i);
      end
    end
  end

  assign can_emit = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    enc_sh_nxt    = enc_sh_r;
    enc_cnt_nxt   = enc_cnt_r;
    enc_found_nxt = enc_found_r;
    dec_acc_nxt   = dec_acc_r;
    dec_gb_nxt    = dec_gb_r;
    dec_first_nxt = dec_first_r;
    dec_bad_nxt   = dec_bad_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_data.func == FUNC_ENCODE) begin
            if (in_data.value[VALUE_W-1:0] == '0) begin
              state_nxt = ST_ZERO;
            end else if (grp_bits_r != 3'd0) begin
              state_nxt     = ST_ENC;
              enc_sh_nxt    = {7'd0, in_data.value[VALUE_W-1:0]};
              enc_cnt_nxt   = NGRP[grp_bits_r];
              enc_found_nxt = 1'b0;
            end
          end else begin
            if (dec_first_r) begin
              dec_first_nxt = 1'b0;
              if (in_data.in_byte == BAD_HEADER) begin
                dec_bad_nxt = 1'b1;
                dec_gb_nxt  = 3'd0;
                dec_acc_nxt = '0;
              end else begin
                dec_bad_nxt = 1'b0;
                dec_gb_nxt  = hdr_g;
                dec_acc_nxt = VALUE_W'(in_data.in_byte & ~(8'hff << hdr_g));
              end
            end else if (!dec_bad_r) begin
              dec_acc_nxt = (dec_acc_r << dec_gb_r)
                          | VALUE_W'(in_data.in_byte & ~(8'hff << dec_gb_r));
            end
            if (in_data.in_last) begin
              state_nxt = ST_DOUT;
            end
          end
        end
      end
      ST_ZERO: begin
        if (can_emit) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.out_kind  = KIND_BYTE;
          out_data_nxt.out_byte  = 8'd0;
          out_data_nxt.out_last  = 1'b1;
          out_data_nxt.out_value = 64'd0;
          state_nxt              = ST_IDLE;
        end
      end
      ST_ENC: begin
        if (can_emit) begin
          if (enc_found_r || enc_grp != 7'd0) begin
            out_valid_nxt          = 1'b1;
            out_data_nxt.out_kind  = KIND_BYTE;
            out_data_nxt.out_byte  = {1'b0, enc_grp}
                                   | (enc_found_r ? 8'd0 : MARK[grp_bits_r]);
            out_data_nxt.out_last  = (enc_cnt_r == CNT_W'(1));
            out_data_nxt.out_value = 64'd0;
            enc_found_nxt          = 1'b1;
          end
          enc_sh_nxt  = enc_sh_r << grp_bits_r;
          enc_cnt_nxt = enc_cnt_r - CNT_W'(1);
          if (enc_cnt_r == CNT_W'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_DOUT: begin
        if (can_emit) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.out_kind  = dec_bad_r ? KIND_ERROR : KIND_VALUE;
          out_data_nxt.out_byte  = 8'd0;
          out_data_nxt.out_last  = 1'b1;
          out_data_nxt.out_value = 64'(dec_acc_r);
          dec_acc_nxt            = '0;
          dec_gb_nxt             = 3'd0;
          dec_first_nxt          = 1'b1;
          dec_bad_nxt            = 1'b0;
          state_nxt              = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      enc_cnt_r   <= '0;
      enc_found_r <= 1'b0;
      dec_acc_r   <= '0;
      dec_gb_r    <= 3'd0;
      dec_first_r <= 1'b1;
      dec_bad_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      enc_cnt_r   <= enc_cnt_nxt;
      enc_found_r <= enc_found_nxt;
      dec_acc_r   <= dec_acc_nxt;
      dec_gb_r    <= dec_gb_nxt;
      dec_first_r <= dec_first_nxt;
      dec_bad_r   <= dec_bad_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    enc_sh_r   <= enc_sh_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |-> state_r == ST_IDLE)
    else $error("transaction accepted while busy");

  a_enc_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_ENC |-> enc_cnt_r != '0)
    else $error("encode running with no groups left");

  a_enc_last: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_ENC && enc_cnt_r == CNT_W'(1) && can_emit
    |=> out_valid_r && out_data_r.out_last && out_data_r.out_kind == KIND_BYTE)
    else $error("encode run ended without a last byte");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.out_kind == KIND_ERROR
    |-> out_data_r.out_value == 64'd0 && out_data_r.out_last)
    else $error("error result carries a value");
`endif

endmodule
